// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the I2C master bit engine.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/i2cbe_pkg.sv -----
// Types, constants and the segment pin function of the I2C master bit engine.
// No dependencies.
package i2cbe_pkg;

    localparam logic [3:0] NBITS   = 4'd8;
    localparam logic [3:0] MSB_POS = 4'd7;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_STOP  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef struct packed {
        logic scl;
        logic sda;
        logic en;
    } pin_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] bit_idx;
        logic [7:0] shift;
        mode_t      mode;
        pin_t       pins;
        logic       ack_seen;
        logic       ack_send;
        logic [7:0] rx_hold;
    } eng_state_t;

    // pin levels set at the start of a segment
    function automatic pin_t seg_pins(mode_t mode, phase_t phase, logic [3:0] bit_idx,
                                      logic [7:0] shift, logic ack_send, pin_t pins);
        pin_t p;
        p = pins;
        if (mode == MODE_START || mode == MODE_STOP) begin
            p.scl = 1'b1;
            p.en  = 1'b1;
            if (mode == MODE_START) begin
                p.sda = (phase == PH_LOW);
            end else begin
                p.sda = (phase == PH_HIGH);
            end
        end else if (phase == PH_HIGH) begin
            p.scl = 1'b1;
        end else begin
            p.scl = 1'b0;
            if (mode == MODE_WRITE) begin
                if (bit_idx < NBITS) begin
                    p.en  = 1'b1;
                    p.sda = shift[3'(MSB_POS - bit_idx)];
                end else begin
                    p.en  = 1'b0;
                    p.sda = 1'b1;
                end
            end else begin
                if (bit_idx < NBITS) begin
                    p.en  = 1'b0;
                    p.sda = 1'b1;
                end else begin
                    p.en  = 1'b1;
                    p.sda = ack_send;
                end
            end
        end
        return p;
    endfunction

endpackage

// ----- hdl/i2cbe_step.sv -----
// One tick of the bit engine: next state, delay count and done flag.
// Depends on i2cbe_pkg.
module i2cbe_step #(
    parameter int DELAY_WIDTH = 16
) (
    input  i2cbe_pkg::eng_state_t   cur,
    input  logic [DELAY_WIDTH-1:0]  dly_cur,
    input  logic [15:0]             half_period,
    input  logic                    cmd_valid,
    input  logic [1:0]              mode,
    input  logic [7:0]              tx_byte,
    input  logic                    ack_level,
    input  logic                    sda_sample,
    output i2cbe_pkg::eng_state_t   nxt,
    output logic [DELAY_WIDTH-1:0]  dly_nxt,
    output logic                    done
);
    import i2cbe_pkg::*;

    localparam int EXT_W = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;

    logic [EXT_W-1:0]       hp_ext;
    logic [DELAY_WIDTH-1:0] hp_mask;
    logic [DELAY_WIDTH-1:0] load;
    logic [DELAY_WIDTH-1:0] dec;

    assign hp_ext  = EXT_W'(half_period);
    assign hp_mask = hp_ext[DELAY_WIDTH-1:0];
    // zero delay runs as one tick
    assign load    = (hp_mask == '0) ? DELAY_WIDTH'(1) : hp_mask;
    assign dec     = dly_cur - DELAY_WIDTH'(1);

    always_comb begin
        nxt     = cur;
        dly_nxt = dly_cur;
        done    = 1'b0;
        unique case (cur.phase)
            PH_IDLE: begin
                if (cmd_valid) begin
                    nxt.mode    = mode_t'(mode);
                    nxt.bit_idx = '0;
                    nxt.phase   = PH_LOW;
                    if (mode_t'(mode) == MODE_WRITE) begin
                        nxt.shift = tx_byte;
                    end else if (mode_t'(mode) == MODE_READ) begin
                        nxt.shift    = '0;
                        nxt.ack_send = ack_level;
                    end
                    nxt.pins = seg_pins(nxt.mode, PH_LOW, '0, nxt.shift,
                                        nxt.ack_send, cur.pins);
                    dly_nxt  = load;
                end
            end
            PH_LOW: begin
                dly_nxt = dec;
                if (dec == '0) begin
                    nxt.phase = PH_HIGH;
                    nxt.pins  = seg_pins(cur.mode, PH_HIGH, cur.bit_idx, cur.shift,
                                         cur.ack_send, cur.pins);
                    dly_nxt   = load;
                end
            end
            PH_HIGH: begin
                dly_nxt = dec;
                if (dec == '0) begin
                    if (cur.mode == MODE_WRITE || cur.mode == MODE_READ) begin
                        if (cur.mode == MODE_READ && cur.bit_idx < NBITS) begin
                            nxt.shift[3'(MSB_POS - cur.bit_idx)] =
                                cur.shift[3'(MSB_POS - cur.bit_idx)] | sda_sample;
                        end
                        if (cur.mode == MODE_WRITE && cur.bit_idx == NBITS) begin
                            nxt.ack_seen = sda_sample;
                        end
                        if (cur.bit_idx < NBITS) begin
                            nxt.bit_idx = cur.bit_idx + 4'd1;
                            nxt.phase   = PH_LOW;
                            nxt.pins    = seg_pins(cur.mode, PH_LOW, nxt.bit_idx,
                                                   nxt.shift, cur.ack_send, cur.pins);
                            dly_nxt     = load;
                        end else begin
                            nxt.pins.scl = 1'b0;
                            if (cur.mode == MODE_READ) begin
                                nxt.rx_hold = cur.shift;
                            end
                            nxt.phase = PH_IDLE;
                            dly_nxt   = '0;
                            done      = 1'b1;
                        end
                    end else begin
                        // start ends with SCL low, stop leaves SCL high
                        if (cur.mode == MODE_START) begin
                            nxt.pins.scl = 1'b0;
                        end
                        nxt.phase = PH_IDLE;
                        dly_nxt   = '0;
                        done      = 1'b1;
                    end
                end
            end
            default: begin
                nxt.phase = PH_IDLE;
                dly_nxt   = '0;
            end
        endcase
    end

endmodule

// ----- hdl/i2c_master_bit_engine.sv -----
// I2C master bit engine: an accepted item is registered in the input register, then processed
// into the result register, from which it is taken; throughput one item per cycle while
// results are taken, each item being one engine tick.
// A waiting result blocks processing; the input register still takes one more item.
// Reset (aresetn low, synchronous): idle, SCL high, SDA driven high, half_period 250.
// Depends on i2cbe_pkg, i2cbe_step and assert_macros.svh.
`include "assert_macros.svh"

module i2c_master_bit_engine #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config: half_period, ticks per half SCL period
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] ack_level, [9] sda_sample
    input  logic [2:0]  s_axis_tuser,   // [0] cmd_valid, [2:1] mode
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] scl_level, [1] sda_level, [2] sda_enable,
                                        // [3] busy_res, [4] done_res, [12:5] rx_byte,
                                        // [13] ack_seen
);
    import i2cbe_pkg::*;

    localparam eng_state_t ST_RESET = '{
        phase:    PH_IDLE,
        bit_idx:  '0,
        shift:    '0,
        mode:     MODE_START,
        pins:     '{scl: 1'b1, sda: 1'b1, en: 1'b1},
        ack_seen: 1'b0,
        ack_send: 1'b0,
        rx_hold:  '0
    };

    // config register
    logic [15:0] half_period_reg;

    // input register
    logic        in_valid_reg;
    logic [15:0] in_data_reg;
    logic [2:0]  in_user_reg;

    // engine state
    eng_state_t             st_reg, st_next;
    logic [DELAY_WIDTH-1:0] dly_reg, dly_next;
    logic                   done;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_data_reg;

    logic advance;

    // a tick is processed when the input register holds one and the result slot is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= 16'd250;
        end else if (cfg_wr_en) begin
            half_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
    end

    i2cbe_step #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_step (
        .cur         (st_reg),
        .dly_cur     (dly_reg),
        .half_period (half_period_reg),
        .cmd_valid   (in_user_reg[0]),
        .mode        (in_user_reg[2:1]),
        .tx_byte     (in_data_reg[7:0]),
        .ack_level   (in_data_reg[8]),
        .sda_sample  (in_data_reg[9]),
        .nxt         (st_next),
        .dly_nxt     (dly_next),
        .done        (done)
    );

    // engine state only moves when a tick is processed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_RESET;
            dly_reg <= '0;
        end else if (advance) begin
            st_reg  <= st_next;
            dly_reg <= dly_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {2'b00, st_next.ack_seen, st_next.rx_hold, done,
                             (st_next.phase != PH_IDLE), st_next.pins.en,
                             st_next.pins.sda, st_next.pins.scl};
        end
    end

    // a done tick always reports the engine as no longer busy
    `ASSERT_NEVER(a_done_not_busy, aclk, aresetn, out_valid_reg && out_data_reg[4] && out_data_reg[3], "done with busy set")
    // an active segment always has ticks left to count
    `ASSERT_NEVER(a_active_dly, aclk, aresetn, (st_reg.phase != PH_IDLE) && (dly_reg == '0), "active segment with zero delay count")
    // bit counter never runs past the ack slot
    `ASSERT_ALWAYS(a_bit_range, aclk, aresetn, st_reg.bit_idx <= NBITS, "bit index past ack slot")
    // state holds whenever no tick is processed
    `ASSERT_ALWAYS(a_hold, aclk, aresetn, !$past(advance) && $past(aresetn) |-> $stable(st_reg), "state moved without a tick")

endmodule
